// ===== rtl/core/irc_line_tokenizer_unit_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef IRC_LINE_TOKENIZER_UNIT_MACROS_SVH
`define IRC_LINE_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define IRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled in reset.
`define IRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define IRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/irctok_pkg.sv =====
// Types and constants shared by the line tokenizer modules.
package irctok_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_LINE,
        PH_PFX_FIRST,
        PH_PFX,
        PH_CMD_FIRST,
        PH_CMD,
        PH_PAR_FIRST,
        PH_MID,
        PH_TRL_FIRST,
        PH_TRL
    } t_phase;

    typedef enum logic [1:0] {
        EV_BYTE,
        EV_EMPTY,
        EV_EOM
    } t_event;

    typedef enum logic [1:0] {
        TT_PREFIX,
        TT_COMMAND,
        TT_MIDDLE,
        TT_TRAILING
    } t_tok_type;

    typedef struct packed {
        t_event     event_res;
        t_tok_type  token_type;
        logic [3:0] param_index;
        logic       token_start;
        logic [7:0] out_byte;
        logic       prefix_ok;
        logic       param_overflow;
        logic       last;
    } t_tok_res;

    // Up to two results produced by one byte, first result in slot 0.
    typedef struct packed {
        logic [1:0]         count;
        t_tok_res [1:0]     res;
    } t_push;

endpackage

// ===== rtl/core/irctok_stream_if.sv =====
// Valid/ready stream interface carrying one item per handshake.
interface irctok_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/irctok_step.sv =====
// Tokenizer state and per-byte classification logic.
module irctok_step #(
    parameter int MAX_PARAMS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    output irctok_pkg::t_push    o_push
);
    import irctok_pkg::*;

    localparam int CW = $clog2(MAX_PARAMS + 2);

    typedef struct packed {
        t_phase          phase;
        logic [CW-1:0]   cnt;
        logic            ovf;
    } t_pstate;

    typedef struct packed {
        t_pstate   st;
        logic      emit;
        t_tok_res  res;
    } t_cres;

    t_phase        r_phase, n_phase;
    logic          r_cr_pending, n_cr_pending;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;

    function automatic logic [3:0] f_idx(logic [CW-1:0] cnt);
        logic [CW-1:0] k;
        k = (cnt > CW'(MAX_PARAMS)) ? CW'(MAX_PARAMS) : cnt;
        return 4'(k);
    endfunction

    function automatic t_tok_res f_res(t_event ev, t_tok_type tt, logic [3:0] idx,
                                       logic start, logic [7:0] b, logic pok,
                                       logic ovf);
        t_tok_res r;
        r.event_res      = ev;
        r.token_type     = tt;
        r.param_index    = idx;
        r.token_start    = start;
        r.out_byte       = b;
        r.prefix_ok      = pok;
        r.param_overflow = ovf;
        r.last           = 1'b0;
        return r;
    endfunction

    // One content byte against the parse state.
    function automatic t_cres f_content(t_pstate s, logic [7:0] c);
        t_cres o;
        o.st   = s;
        o.emit = 1'b0;
        o.res  = f_res(EV_BYTE, TT_PREFIX, 4'd0, 1'b0, 8'd0, 1'b1, s.ovf);
        case (s.phase)
            PH_LINE, PH_CMD_FIRST: begin
                if (s.phase == PH_LINE && c == CH_COLON) begin
                    o.st.phase = PH_PFX_FIRST;
                end else if (c == CH_SPACE) begin
                    o.emit     = 1'b1;
                    o.res      = f_res(EV_EMPTY, TT_COMMAND, 4'd0, 1'b1, 8'd0, 1'b1, s.ovf);
                    o.st.phase = PH_PAR_FIRST;
                end else begin
                    o.emit     = 1'b1;
                    o.res      = f_res(EV_BYTE, TT_COMMAND, 4'd0, 1'b1, c, 1'b1, s.ovf);
                    o.st.phase = PH_CMD;
                end
            end
            PH_PFX_FIRST, PH_PFX: begin
                if (c == CH_SPACE) begin
                    o.st.phase = PH_CMD_FIRST;
                end else begin
                    o.emit     = 1'b1;
                    o.res      = f_res(EV_BYTE, TT_PREFIX, 4'd0, s.phase == PH_PFX_FIRST,
                                       c, 1'b1, s.ovf);
                    o.st.phase = PH_PFX;
                end
            end
            PH_CMD: begin
                if (c == CH_SPACE) begin
                    o.st.phase = PH_PAR_FIRST;
                end else begin
                    o.emit = 1'b1;
                    o.res  = f_res(EV_BYTE, TT_COMMAND, 4'd0, 1'b0, c, 1'b1, s.ovf);
                end
            end
            PH_PAR_FIRST: begin
                // a parameter opening past the limit latches overflow
                o.st.ovf = s.ovf | (s.cnt > CW'(MAX_PARAMS));
                if (c == CH_COLON) begin
                    o.st.phase = PH_TRL_FIRST;
                end else if (c == CH_SPACE) begin
                    o.emit = 1'b1;
                    o.res  = f_res(EV_EMPTY, TT_MIDDLE, f_idx(s.cnt), 1'b1, 8'd0, 1'b1,
                                   o.st.ovf);
                    if (s.cnt <= CW'(MAX_PARAMS)) begin
                        o.st.cnt = s.cnt + CW'(1);
                    end
                end else begin
                    o.emit     = 1'b1;
                    o.res      = f_res(EV_BYTE, TT_MIDDLE, f_idx(s.cnt), 1'b1, c, 1'b1,
                                       o.st.ovf);
                    o.st.phase = PH_MID;
                end
            end
            PH_MID: begin
                if (c == CH_SPACE) begin
                    if (s.cnt <= CW'(MAX_PARAMS)) begin
                        o.st.cnt = s.cnt + CW'(1);
                    end
                    o.st.phase = PH_PAR_FIRST;
                end else begin
                    o.emit = 1'b1;
                    o.res  = f_res(EV_BYTE, TT_MIDDLE, f_idx(s.cnt), 1'b0, c, 1'b1, s.ovf);
                end
            end
            PH_TRL_FIRST: begin
                o.emit     = 1'b1;
                o.res      = f_res(EV_BYTE, TT_TRAILING, f_idx(s.cnt), 1'b1, c, 1'b1, s.ovf);
                o.st.phase = PH_TRL;
            end
            default: begin
                o.emit     = 1'b1;
                o.res      = f_res(EV_BYTE, TT_TRAILING, f_idx(s.cnt), 1'b0, c, 1'b1, s.ovf);
                o.st.phase = PH_TRL;
            end
        endcase
        return o;
    endfunction

    t_pstate  w_s0, w_s1, w_sn;
    t_cres    w_c0, w_c1;
    logic     w_e0, w_e1;
    t_tok_res w_r0, w_r1;

    always_comb begin
        w_s0 = '{phase: r_phase, cnt: r_cnt, ovf: r_ovf};
        w_c0 = f_content(w_s0, CH_CR);
        w_s1 = r_cr_pending ? w_c0.st : w_s0;
        w_c1 = f_content(w_s1, i_byte);
        n_cr_pending = 1'b0;
        if (i_byte == CH_LF) begin
            // line end: optional empty trailing, then end of message
            w_e0 = (r_phase == PH_TRL_FIRST);
            w_r0 = f_res(EV_EMPTY, TT_TRAILING, f_idx(r_cnt), 1'b1, 8'd0, 1'b1, r_ovf);
            w_e1 = 1'b1;
            w_r1 = f_res(EV_EOM, TT_PREFIX, f_idx(r_cnt), 1'b0, 8'd0,
                         !(r_phase == PH_PFX_FIRST || r_phase == PH_PFX), r_ovf);
            w_sn = '{phase: PH_LINE, cnt: '0, ovf: 1'b0};
        end else begin
            // release a held carriage return as content, then the byte itself
            w_e0 = r_cr_pending & w_c0.emit;
            w_r0 = w_c0.res;
            w_e1 = (i_byte != CH_CR) & w_c1.emit;
            w_r1 = w_c1.res;
            w_sn = (i_byte == CH_CR) ? w_s1 : w_c1.st;
            n_cr_pending = (i_byte == CH_CR);
        end
        n_phase = w_sn.phase;
        n_cnt   = w_sn.cnt;
        n_ovf   = w_sn.ovf;

        o_push.count  = {1'b0, w_e0} + {1'b0, w_e1};
        o_push.res[0] = w_e0 ? w_r0 : w_r1;
        o_push.res[1] = w_r1;
        if (w_e0 && w_e1) begin
            o_push.res[1].last = 1'b1;
        end else begin
            o_push.res[0].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LINE;
            r_cr_pending <= 1'b0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_cr_pending <= n_cr_pending;
            r_cnt        <= n_cnt;
            r_ovf        <= n_ovf;
        end
    end

endmodule

// ===== rtl/core/irctok_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one.
module irctok_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  irctok_pkg::t_push             i_push,
    output logic [irctok_pkg::LVL_W-1:0]  o_level,
    irctok_stream_if.source               o_tok
);
    import irctok_pkg::*;

    t_tok_res               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_rptr, n_rptr;
    logic [PTR_W-1:0]       r_wptr, n_wptr;
    logic [LVL_W-1:0]       r_level, n_level;
    logic                   w_pop;
    logic [PTR_W-1:0]       w_wptr1;

    assign w_pop       = o_tok.valid && o_tok.ready;
    assign w_wptr1     = r_wptr + PTR_W'(1);
    assign o_tok.valid = (r_level != '0);
    assign o_tok.data  = r_mem[r_rptr];
    assign o_level     = r_level;

    always_comb begin
        n_rptr  = r_rptr + PTR_W'(w_pop);
        n_wptr  = r_wptr + PTR_W'(i_push.count);
        n_level = r_level + LVL_W'(i_push.count) - LVL_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr  <= '0;
            r_wptr  <= '0;
            r_level <= '0;
        end else begin
            r_rptr  <= n_rptr;
            r_wptr  <= n_wptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.res[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wptr1] <= i_push.res[1];
        end
    end

endmodule

// ===== rtl/core/irc_line_tokenizer_unit.sv =====
// Top level of the chat-protocol line tokenizer.
//
// Takes one raw byte per cycle and returns zero, one or two result items per
// byte, each tagging a content byte (or an empty token, or end of message)
// with its token class, parameter index and token-start mark. A byte sits in
// the input register, where the state update and classification are done in
// a single pass, and its results enter a four-entry result queue; the first
// result can be taken once the byte has left the input register and its
// results are queued. The input register moves on whenever the queue holds
// two results or fewer, so a new byte is taken every cycle while the output
// side keeps draining; with three or more results waiting the input stalls.
// The output delivers one item per cycle, which sets the sustained rate: one
// byte per cycle as long as bytes average no more than one result each (a
// held carriage return that turns into content, and an empty trailing
// parameter at line end, are the only sources of a second result).
// MAX_PARAMS sets where the parameter index saturates and the overflow flag
// rises.
module irc_line_tokenizer_unit #(
    parameter int MAX_PARAMS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    irctok_stream_if.sink     i_byte,
    irctok_stream_if.source   o_tok
);
    import irctok_pkg::*;

`include "irc_line_tokenizer_unit_macros.svh"

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_byte;
    logic              w_fire;
    logic              w_room;
    logic [LVL_W-1:0]  w_level;
    t_push             w_push;
    t_push             w_push_q;
    logic              w_eom_shape;

    // Advance the input register only when the queue can absorb two results.
    assign w_room       = (w_level <= LVL_W'(FIFO_DEPTH - 2));
    assign w_fire       = r_in_valid && w_room;
    assign i_byte.ready = !r_in_valid || w_fire;

    // Hold back results unless the byte is really consumed this cycle.
    always_comb begin
        w_push_q = w_push;
        if (!w_fire) begin
            w_push_q.count = 2'd0;
        end
        n_in_valid = (i_byte.valid && i_byte.ready) || (r_in_valid && !w_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data;
        end
    end

    irctok_step #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_push  (w_push)
    );

    irctok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push_q),
        .o_level (w_level),
        .o_tok   (o_tok)
    );

    // End of message: token class field at TT_PREFIX, no start mark, no byte, always the last item.
    assign w_eom_shape = (o_tok.data.token_type == TT_PREFIX) && !o_tok.data.token_start
                         && (o_tok.data.out_byte == 8'd0) && o_tok.data.last;

    // Queue never overfills.
    `IRC_ASSERT_IMPL(a_level_bound, i_clk, i_rst_n, 1'b1, w_level <= LVL_W'(FIFO_DEPTH))
    // End of message carries no token content.
    `IRC_ASSERT_IMPL(a_eom_shape, i_clk, i_rst_n, o_tok.valid && o_tok.data.event_res == EV_EOM, w_eom_shape)
    // Only token-byte results carry a byte.
    `IRC_ASSERT_IMPL(a_empty_byte, i_clk, i_rst_n, o_tok.valid && o_tok.data.event_res != EV_BYTE, o_tok.data.out_byte == 8'd0)
    // An accepted byte is held in the input register next cycle.
    `IRC_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n, i_byte.valid && i_byte.ready, r_in_valid)

endmodule
